>>> hdl/x86e_pkg.sv
// ----------------------------------------------------------------------------
// x86e_pkg
// shared types and codes for the 8086 execute subset
// ----------------------------------------------------------------------------
package x86e_pkg;

    // request codes
    localparam logic [2:0] REQ_MOV  = 3'd0;
    localparam logic [2:0] REQ_ADD  = 3'd1;
    localparam logic [2:0] REQ_SUB  = 3'd2;
    localparam logic [2:0] REQ_CMP  = 3'd3;
    localparam logic [2:0] REQ_JNZ  = 3'd4;
    localparam logic [2:0] REQ_LOAD = 3'd5;

    // source kinds
    localparam logic [1:0] SRC_IMM = 2'd0;
    localparam logic [1:0] SRC_REG = 2'd1;
    localparam logic [1:0] SRC_MEM = 2'd2;

    // r/m codes
    localparam logic [2:0] RM_BX_SI = 3'd0;
    localparam logic [2:0] RM_BX_DI = 3'd1;
    localparam logic [2:0] RM_BP_SI = 3'd2;
    localparam logic [2:0] RM_BP_DI = 3'd3;
    localparam logic [2:0] RM_SI    = 3'd4;
    localparam logic [2:0] RM_DI    = 3'd5;
    localparam logic [2:0] RM_BP    = 3'd6;
    localparam logic [2:0] RM_BX    = 3'd7;

    // word register numbers
    localparam logic [2:0] GPR_BX = 3'd3;
    localparam logic [2:0] GPR_BP = 3'd5;
    localparam logic [2:0] GPR_SI = 3'd6;
    localparam logic [2:0] GPR_DI = 3'd7;

    typedef struct packed {
        logic [2:0]         req_type;
        logic               width_word;
        logic               dest_is_memory;
        logic [2:0]         dest_code;
        logic [1:0]         src_kind;
        logic [2:0]         src_code;
        logic [15:0]        immediate;
        logic               direct_address;
        logic signed [15:0] displacement;
        logic [2:0]         instr_size;
    } t_in_item;

    typedef struct packed {
        logic [15:0] next_ip;
        logic [15:0] result_value;
        logic        zero_flag;
        logic        sign_flag;
        logic        jump_taken;
        logic        bad_request;
    } t_out_item;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_RS0,
        S_RS1,
        S_RD0,
        S_RD1,
        S_EXE,
        S_WR1
    } t_state;

    // which operand byte the registered ram data belongs to
    typedef enum logic [2:0] {
        CAP_NONE,
        CAP_S0,
        CAP_S1,
        CAP_D0,
        CAP_D1
    } t_cap;

endpackage

>>> hdl/x86e_stream_if.sv
// ----------------------------------------------------------------------------
// x86e_stream_if
// valid/ready channel carrying one item of a given payload type
// ----------------------------------------------------------------------------
interface x86e_stream_if #(
    parameter type t_data = logic
);
    logic  valid;
    logic  ready;
    t_data data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/x86e_ram.sv
// ----------------------------------------------------------------------------
// x86e_ram
// single port synchronous ram, registered read
// ----------------------------------------------------------------------------
module x86e_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> hdl/x86_real_mode_exec_subset_unit.sv
// ----------------------------------------------------------------------------
// x86_real_mode_exec_subset_unit
// executes decoded 8086 mov/add/sub/cmp/jnz items and memory load items
// ----------------------------------------------------------------------------
// one result item per input item. data memory is a single port byte ram
// that every memory byte goes through, one byte a cycle. an item passes an
// idle step that takes it from the input buffer, a read step for each memory
// byte read, an execute step that waits for the output register to be free,
// and a write step for the high byte of a word written to memory. a one-item
// input buffer takes the next item while the current one executes, and an
// output register holds the result until it is taken. after reset a clearing
// pass zeroes the ram, one byte a cycle, during which no item is accepted.
module x86_real_mode_exec_subset_unit #(
    parameter int MEMORY_BYTES = 65536
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    x86e_stream_if.sink          i_in,
    x86e_stream_if.source        o_out
);
    import x86e_pkg::*;

    localparam int IW = $clog2(MEMORY_BYTES);
    localparam logic [IW-1:0] LAST_IDX = IW'(MEMORY_BYTES - 1);

    // wrapped 16-bit address reduced modulo the memory size, restoring steps
    function automatic logic [IW-1:0] f_reduce(input logic [15:0] a);
        logic [23:0] r;
        r = {8'd0, a};
        for (int i = 7; i >= 0; i--) begin
            if (r >= (24'(MEMORY_BYTES) << i)) begin
                r = r - (24'(MEMORY_BYTES) << i);
            end
        end
        return r[IW-1:0];
    endfunction

    // architectural state
    logic [7:0][15:0] r_gpr, n_gpr;    // ax cx dx bx sp bp si di
    logic [15:0]      r_ip, n_ip;
    logic             r_zf, n_zf;
    logic             r_sf, n_sf;

    // control
    t_state           r_state, n_state;
    logic             r_buf_valid;
    t_in_item         r_buf;
    t_in_item         r_cur;
    logic [IW-1:0]    r_clr_idx;
    t_cap             r_cap, n_cap;
    logic             r_out_valid;
    t_out_item        r_out_data, n_out_data;

    // byte indices of the operands
    logic [IW-1:0]    r_si0, r_si1, r_di0, r_di1;
    logic [7:0]       r_sb0, r_sb1, r_db0, r_db1;
    logic [7:0]       r_res_hi;

    // ram port
    logic             ram_we, ram_re;
    logic [IW-1:0]    ram_addr;
    logic [7:0]       ram_wdata, ram_rdata;

    logic             out_free;
    logic             exe_fire;
    logic             take_buf;

    x86e_ram #(
        .WIDTH (8),
        .DEPTH (MEMORY_BYTES)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // handshakes
    // ------------------------------------------------------------------
    assign i_in.ready  = !r_buf_valid && (r_state != S_CLR);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;
    assign out_free    = !r_out_valid || o_out.ready;
    assign take_buf    = (r_state == S_IDLE) && r_buf_valid;

    // ------------------------------------------------------------------
    // effective addresses from the buffered item and current registers
    // ------------------------------------------------------------------
    function automatic logic [15:0] f_ea(input logic [7:0][15:0] g, input logic [2:0] rm,
                                         input logic direct, input logic [15:0] disp);
        logic [15:0] base;
        case (rm)
            RM_BX_SI: base = g[GPR_BX] + g[GPR_SI];
            RM_BX_DI: base = g[GPR_BX] + g[GPR_DI];
            RM_BP_SI: base = g[GPR_BP] + g[GPR_SI];
            RM_BP_DI: base = g[GPR_BP] + g[GPR_DI];
            RM_SI:    base = g[GPR_SI];
            RM_DI:    base = g[GPR_DI];
            RM_BP:    base = direct ? 16'd0 : g[GPR_BP];
            default:  base = g[GPR_BX];
        endcase
        return base + disp;
    endfunction

    logic [15:0] ea_src, ea_dst, ea_dst_sel;
    always_comb begin
        ea_src     = f_ea(r_gpr, r_buf.src_code, r_buf.direct_address, r_buf.displacement);
        ea_dst     = f_ea(r_gpr, r_buf.dest_code, r_buf.direct_address, r_buf.displacement);
        // a load item addresses memory by the displacement alone
        ea_dst_sel = (r_buf.req_type == REQ_LOAD) ? r_buf.displacement : ea_dst;
    end

    // ------------------------------------------------------------------
    // decode of the buffered and current item
    // ------------------------------------------------------------------
    logic buf_alu, buf_src_mem, buf_dst_mem;
    logic cur_alu, cur_src_mem, cur_dst_mem, cur_wr_mem_hi;
    always_comb begin
        buf_alu       = (r_buf.req_type <= REQ_CMP) && (r_buf.src_kind != 2'd3);
        buf_src_mem   = buf_alu && (r_buf.src_kind == SRC_MEM);
        buf_dst_mem   = buf_alu && r_buf.dest_is_memory;
        cur_alu       = (r_cur.req_type <= REQ_CMP) && (r_cur.src_kind != 2'd3);
        cur_src_mem   = cur_alu && (r_cur.src_kind == SRC_MEM);
        cur_dst_mem   = cur_alu && r_cur.dest_is_memory;
        cur_wr_mem_hi = cur_dst_mem && r_cur.width_word && (r_cur.req_type != REQ_CMP);
    end

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLR: begin
                if (r_clr_idx == LAST_IDX) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (r_buf_valid) begin
                    if (buf_src_mem)      n_state = S_RS0;
                    else if (buf_dst_mem) n_state = S_RD0;
                    else                  n_state = S_EXE;
                end
            end
            S_RS0: begin
                if (r_cur.width_word) n_state = S_RS1;
                else if (cur_dst_mem) n_state = S_RD0;
                else                  n_state = S_EXE;
            end
            S_RS1: n_state = cur_dst_mem ? S_RD0 : S_EXE;
            S_RD0: n_state = r_cur.width_word ? S_RD1 : S_EXE;
            S_RD1: n_state = S_EXE;
            S_EXE: begin
                if (out_free) n_state = cur_wr_mem_hi ? S_WR1 : S_IDLE;
            end
            S_WR1:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // operand view: registered ram data forwarded in the cycle it lands
    // ------------------------------------------------------------------
    logic [7:0]  sb0, sb1, db0, db1;
    logic [15:0] mask, src_val, dst_val, result;
    logic [1:0]  bsel_s, bsel_d;

    always_comb begin
        sb0 = (r_cap == CAP_S0) ? ram_rdata : r_sb0;
        sb1 = (r_cap == CAP_S1) ? ram_rdata : r_sb1;
        db0 = (r_cap == CAP_D0) ? ram_rdata : r_db0;
        db1 = (r_cap == CAP_D1) ? ram_rdata : r_db1;
        mask   = r_cur.width_word ? 16'hFFFF : 16'h00FF;
        bsel_s = r_cur.src_code[1:0];
        bsel_d = r_cur.dest_code[1:0];

        // byte codes 0..3 are the low halves, 4..7 the high halves
        case (r_cur.src_kind)
            SRC_IMM: src_val = r_cur.immediate & mask;
            SRC_REG: begin
                if (r_cur.width_word)      src_val = r_gpr[r_cur.src_code];
                else if (r_cur.src_code[2]) src_val = {8'd0, r_gpr[{1'b0, bsel_s}][15:8]};
                else                        src_val = {8'd0, r_gpr[{1'b0, bsel_s}][7:0]};
            end
            default: src_val = r_cur.width_word ? {sb1, sb0} : {8'd0, sb0};
        endcase

        if (r_cur.dest_is_memory) begin
            dst_val = r_cur.width_word ? {db1, db0} : {8'd0, db0};
        end else if (r_cur.width_word) begin
            dst_val = r_gpr[r_cur.dest_code];
        end else if (r_cur.dest_code[2]) begin
            dst_val = {8'd0, r_gpr[{1'b0, bsel_d}][15:8]};
        end else begin
            dst_val = {8'd0, r_gpr[{1'b0, bsel_d}][7:0]};
        end

        case (r_cur.req_type)
            REQ_MOV: result = src_val;
            REQ_ADD: result = (dst_val + src_val) & mask;
            default: result = (dst_val - src_val) & mask;
        endcase
    end

    // ------------------------------------------------------------------
    // outputs of the sequencer: ram port, capture tag, execute step
    // ------------------------------------------------------------------
    always_comb begin
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_addr  = r_si0;
        ram_wdata = 8'd0;
        n_cap     = CAP_NONE;
        exe_fire  = 1'b0;
        case (r_state)
            S_CLR: begin
                ram_we   = 1'b1;
                ram_addr = r_clr_idx;
            end
            S_RS0: begin
                ram_re = 1'b1;
                n_cap  = CAP_S0;
            end
            S_RS1: begin
                ram_re   = 1'b1;
                ram_addr = r_si1;
                n_cap    = CAP_S1;
            end
            S_RD0: begin
                ram_re   = 1'b1;
                ram_addr = r_di0;
                n_cap    = CAP_D0;
            end
            S_RD1: begin
                ram_re   = 1'b1;
                ram_addr = r_di1;
                n_cap    = CAP_D1;
            end
            S_EXE: begin
                exe_fire = out_free;
                ram_addr = r_di0;
                if (r_cur.req_type == REQ_LOAD) begin
                    ram_we    = out_free;
                    ram_wdata = r_cur.immediate[7:0];
                end else if (cur_dst_mem && (r_cur.req_type != REQ_CMP)) begin
                    ram_we    = out_free;
                    ram_wdata = result[7:0];
                end
            end
            S_WR1: begin
                ram_we    = 1'b1;
                ram_addr  = r_di1;
                ram_wdata = r_res_hi;
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // architectural update and result item
    // ------------------------------------------------------------------
    always_comb begin
        n_gpr      = r_gpr;
        n_ip       = r_ip;
        n_zf       = r_zf;
        n_sf       = r_sf;
        n_out_data = r_out_data;
        if (exe_fire) begin
            n_out_data.result_value = 16'd0;
            n_out_data.jump_taken   = 1'b0;
            n_out_data.bad_request  = 1'b0;
            if (r_cur.req_type == REQ_LOAD) begin
                n_out_data.result_value = {8'd0, r_cur.immediate[7:0]};
            end else if (r_cur.req_type == REQ_JNZ) begin
                n_ip = r_ip + {13'd0, r_cur.instr_size};
                if (!r_zf) begin
                    n_ip                  = n_ip + r_cur.immediate;
                    n_out_data.jump_taken = 1'b1;
                end
            end else if (!cur_alu) begin
                n_out_data.bad_request = 1'b1;
                n_ip = r_ip + {13'd0, r_cur.instr_size};
            end else begin
                n_out_data.result_value = result;
                // register destination, cmp writes nothing back
                if (!r_cur.dest_is_memory && (r_cur.req_type != REQ_CMP)) begin
                    if (r_cur.width_word) begin
                        n_gpr[r_cur.dest_code] = result;
                    end else if (r_cur.dest_code[2]) begin
                        n_gpr[{1'b0, bsel_d}][15:8] = result[7:0];
                    end else begin
                        n_gpr[{1'b0, bsel_d}][7:0] = result[7:0];
                    end
                end
                if (r_cur.req_type != REQ_MOV) begin
                    n_zf = (result == 16'd0);
                    n_sf = r_cur.width_word ? result[15] : result[7];
                end
                n_ip = r_ip + {13'd0, r_cur.instr_size};
            end
            n_out_data.next_ip   = n_ip;
            n_out_data.zero_flag = n_zf;
            n_out_data.sign_flag = n_sf;
        end
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_idx   <= '0;
            r_buf_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_cap       <= CAP_NONE;
            r_gpr       <= '0;
            r_ip        <= 16'd0;
            r_zf        <= 1'b0;
            r_sf        <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cap   <= n_cap;
            r_gpr   <= n_gpr;
            r_ip    <= n_ip;
            r_zf    <= n_zf;
            r_sf    <= n_sf;
            if (r_state == S_CLR) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (i_in.valid && i_in.ready) begin
                r_buf_valid <= 1'b1;
            end else if (take_buf) begin
                r_buf_valid <= 1'b0;
            end
            if (exe_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_buf <= i_in.data;
        end
        if (take_buf) begin
            r_cur <= r_buf;
            r_si0 <= f_reduce(ea_src);
            r_si1 <= f_reduce(ea_src + 16'd1);
            r_di0 <= f_reduce(ea_dst_sel);
            r_di1 <= f_reduce(ea_dst + 16'd1);
        end
        if (r_cap == CAP_S0) r_sb0 <= ram_rdata;
        if (r_cap == CAP_S1) r_sb1 <= ram_rdata;
        if (r_cap == CAP_D0) r_db0 <= ram_rdata;
        if (r_cap == CAP_D1) r_db1 <= ram_rdata;
        if (exe_fire) begin
            r_res_hi <= result[15:8];
        end
        r_out_data <= n_out_data;
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_no_write_in_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RS0 || r_state == S_RS1 || r_state == S_RD0 || r_state == S_RD1)
        |-> !ram_we)
        else $error("ram written during an operand read step");

    a_exe_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exe_fire |=> r_out_valid)
        else $error("execute step left no result item");

    a_clear_no_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |-> !r_buf_valid)
        else $error("item buffered during clearing pass");

    a_capture_follows_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_re |=> (r_cap != CAP_NONE))
        else $error("ram read data not captured");

endmodule

>>> tb/x86_real_mode_exec_subset_unit_test.sv
// ----------------------------------------------------------------------------
// x86_real_mode_exec_subset_unit_test
// drives decoded instruction items into the execute unit and checks every
// result item against a behavioural copy of the machine state
// ----------------------------------------------------------------------------
module x86_real_mode_exec_subset_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import x86e_pkg::*;

    localparam int MEM_BYTES = 65536;
    localparam int STALL_LIMIT = 200000;

    // behavioural copy of the machine and queue of expected result items
    class exec_scoreboard;
        logic [7:0]  regs [16];
        logic [7:0]  mem [MEM_BYTES];
        logic        zf, sf;
        logic [15:0] ip;
        t_out_item   pending_results [$];
        int          mismatches;
        int          checked;

        function new();
            foreach (regs[i]) regs[i] = '0;
            foreach (mem[i]) mem[i] = '0;
            zf = 0; sf = 0; ip = '0;
            mismatches = 0; checked = 0;
        endfunction

        // byte position of a word or byte register number in the file
        function int reg_pos(logic [2:0] code, logic wide);
            int wpos [8] = '{0, 4, 6, 2, 8, 10, 12, 14};
            int bpos [8] = '{0, 4, 6, 2, 1, 5, 7, 3};
            return wide ? wpos[code] : bpos[code];
        endfunction

        function logic [15:0] reg_word(int pos);
            return {regs[(pos + 1) & 15], regs[pos & 15]};
        endfunction

        function logic [15:0] read_reg(logic [2:0] code, logic wide);
            int p;
            p = reg_pos(code, wide);
            return wide ? reg_word(p) : {8'h00, regs[p]};
        endfunction

        function void write_reg(logic [2:0] code, logic wide, logic [15:0] v);
            int p;
            p = reg_pos(code, wide);
            regs[p] = v[7:0];
            if (wide) regs[(p + 1) & 15] = v[15:8];
        endfunction

        function logic [15:0] ea(logic [2:0] rm, logic direct, logic [15:0] disp);
            logic [15:0] bx, bp, si, di, base;
            bx = reg_word(2); bp = reg_word(10); si = reg_word(12); di = reg_word(14);
            case (rm)
                RM_BX_SI: base = bx + si;
                RM_BX_DI: base = bx + di;
                RM_BP_SI: base = bp + si;
                RM_BP_DI: base = bp + di;
                RM_SI:    base = si;
                RM_DI:    base = di;
                RM_BP:    base = direct ? 16'h0000 : bp;
                default:  base = bx;
            endcase
            return base + disp;
        endfunction

        function logic [15:0] read_mem(logic [15:0] a, logic wide);
            logic [15:0] a1;
            a1 = a + 16'd1;
            return wide ? {mem[a1], mem[a]} : {8'h00, mem[a]};
        endfunction

        function void write_mem(logic [15:0] a, logic wide, logic [15:0] v);
            logic [15:0] a1;
            a1 = a + 16'd1;
            mem[a] = v[7:0];
            if (wide) mem[a1] = v[15:8];
        endfunction

        // executes one instruction item and queues its result
        function void note_instruction(t_in_item it);
            t_out_item   r;
            logic [15:0] mask, src, dst, daddr, res, load_addr;
            r = '0;
            mask = it.width_word ? 16'hFFFF : 16'h00FF;
            if (it.req_type == REQ_LOAD) begin
                // byte address taken as an unsigned 16-bit value
                load_addr = it.displacement;
                r.result_value = {8'h00, it.immediate[7:0]};
                mem[load_addr] = it.immediate[7:0];
            end else if (it.req_type == REQ_JNZ) begin
                ip = ip + it.instr_size;
                if (!zf) begin
                    ip = ip + it.immediate;
                    r.jump_taken = 1;
                end
            end else if (it.req_type > REQ_LOAD || it.src_kind == 2'd3) begin
                r.bad_request = 1;
                ip = ip + it.instr_size;
            end else begin
                daddr = '0;
                if (it.src_kind == SRC_IMM) src = it.immediate & mask;
                else if (it.src_kind == SRC_REG) src = read_reg(it.src_code, it.width_word);
                else src = read_mem(ea(it.src_code, it.direct_address, it.displacement),
                                    it.width_word);
                if (it.dest_is_memory) begin
                    daddr = ea(it.dest_code, it.direct_address, it.displacement);
                    dst = read_mem(daddr, it.width_word);
                end else begin
                    dst = read_reg(it.dest_code, it.width_word);
                end
                if (it.req_type == REQ_MOV) res = src;
                else if (it.req_type == REQ_ADD) res = (dst + src) & mask;
                else res = (dst - src) & mask;
                if (it.req_type != REQ_CMP) begin
                    if (it.dest_is_memory) write_mem(daddr, it.width_word, res);
                    else write_reg(it.dest_code, it.width_word, res);
                end
                if (it.req_type != REQ_MOV) begin
                    zf = (res == 16'h0000);
                    sf = it.width_word ? res[15] : res[7];
                end
                r.result_value = res;
                ip = ip + it.instr_size;
            end
            r.next_ip = ip;
            r.zero_flag = zf;
            r.sign_flag = sf;
            pending_results.push_back(r);
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            checked++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result item %p", got);
                return;
            end
            want = pending_results.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d mismatch: expected %p, got %p", checked, want, got);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    x86e_stream_if #(.t_data(t_in_item))  instr_ch ();
    x86e_stream_if #(.t_data(t_out_item)) result_ch ();

    x86_real_mode_exec_subset_unit #(.MEMORY_BYTES(MEM_BYTES)) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (instr_ch.sink),
        .o_out   (result_ch.source)
    );

    exec_scoreboard sb;
    int  idle_cycles;
    int  sent;
    bit  stim_done;
    int  n_loads, n_jumps_taken;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // watchdog: cycles without any accepted item on either channel
    always @(posedge i_clk) begin
        if ((instr_ch.valid && instr_ch.ready) || (result_ch.valid && result_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("x86_real_mode_exec_subset_unit verification failed");
            $finish;
        end
    end

    // result side: random stalls, checks at the rising edge
    initial begin
        int gap;
        result_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
            if (gap != 0) begin
                result_ch.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!result_ch.valid);
            if (result_ch.data.jump_taken) n_jumps_taken++;
            sb.check_result(result_ch.data);
        end
    end

    // sends one item, holding valid until it is taken
    task automatic send_item(t_in_item it);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap != 0) begin
            instr_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        instr_ch.data  <= it;
        instr_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!instr_ch.ready);
        sb.note_instruction(it);
        if (it.req_type == REQ_LOAD) n_loads++;
        sent++;
        @(negedge i_clk);
    endtask

    function automatic t_in_item make_op(logic [2:0] req, logic wide, logic dmem,
                                         logic [2:0] dcode, logic [1:0] skind,
                                         logic [2:0] scode, logic [15:0] imm,
                                         logic direct, logic [15:0] disp,
                                         logic [2:0] size);
        t_in_item it;
        it = '{req, wide, dmem, dcode, skind, scode, imm, direct, disp, size};
        return it;
    endfunction

    // mostly small addresses so memory operands hit bytes already placed
    function automatic t_in_item random_item();
        t_in_item it;
        int pick;
        it = t_in_item'($bits(t_in_item)'({$urandom, $urandom}));
        pick = $urandom_range(0, 99);
        if (pick < 12) it.req_type = REQ_LOAD;
        else if (pick < 22) it.req_type = REQ_JNZ;
        else if (pick < 25) it.req_type = 3'($urandom_range(6, 7));
        else it.req_type = 3'($urandom_range(0, 3));
        if (pick >= 25 && $urandom_range(0, 19) != 0) it.src_kind = 2'($urandom_range(0, 2));
        if ($urandom_range(0, 3) != 0) it.displacement = 16'($urandom_range(0, 63));
        if ($urandom_range(0, 9) != 0) it.instr_size = 3'($urandom_range(1, 6));
        return it;
    endfunction

    initial begin
        sb = new();
        idle_cycles = 0;
        sent = 0; n_loads = 0; n_jumps_taken = 0;
        stim_done = 0;
        i_rst_n = 1'b0;
        instr_ch.valid = 1'b0;
        instr_ch.data  = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, every operation, aliasing and wrap cases
        send_item(make_op(REQ_JNZ, 0, 0, 0, SRC_IMM, 0, 16'h0010, 0, 0, 2)); // zf clear: taken
        send_item(make_op(REQ_MOV, 1, 0, GPR_BX, SRC_IMM, 0, 16'hFFFF, 0, 0, 3));
        send_item(make_op(REQ_MOV, 1, 0, GPR_SI, SRC_IMM, 0, 16'h0002, 0, 0, 3));
        send_item(make_op(REQ_MOV, 1, 0, GPR_DI, SRC_IMM, 0, 16'h8000, 0, 0, 3));
        send_item(make_op(REQ_MOV, 1, 0, GPR_BP, SRC_IMM, 0, 16'h7FFF, 0, 0, 3));
        send_item(make_op(REQ_MOV, 0, 0, 3'd6, SRC_IMM, 0, 16'h00A5, 0, 0, 2)); // dh alone
        send_item(make_op(REQ_LOAD, 0, 0, 0, SRC_IMM, 0, 16'h12FE, 0, 16'hFFFF, 4));
        send_item(make_op(REQ_LOAD, 0, 0, 0, SRC_IMM, 0, 16'h0034, 0, 16'h0000, 4));
        send_item(make_op(REQ_MOV, 1, 0, 3'd0, SRC_MEM, RM_BP, 0, 1, 16'hFFFF, 4)); // wrap
        for (int rm = 0; rm < 8; rm++)
            send_item(make_op(REQ_ADD, 1, 1, 3'(rm), SRC_REG, 3'(rm), 0, 0, 16'h8000, 6));
        send_item(make_op(REQ_SUB, 0, 0, 3'd0, SRC_REG, 3'd0, 0, 0, 0, 2)); // zero result
        send_item(make_op(REQ_JNZ, 0, 0, 0, SRC_IMM, 0, 16'hFFF0, 0, 0, 2)); // not taken
        send_item(make_op(REQ_CMP, 0, 0, 3'd0, SRC_IMM, 0, 16'h0001, 0, 0, 3)); // sign set
        send_item(make_op(REQ_MOV, 0, 0, 0, 2'd3, 0, 0, 0, 0, 7));            // bad source
        send_item(make_op(3'd7, 1, 1, 7, SRC_IMM, 7, 16'hFFFF, 1, 16'h7FFF, 0)); // bad request
        send_item(make_op(REQ_SUB, 1, 1, RM_DI, SRC_MEM, RM_SI, 16'hFFFF, 0, 16'h8000, 1));

        for (int i = 0; i < 1700; i++) send_item(random_item());
        instr_ch.valid <= 1'b0;
        stim_done = 1;

        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("ran %0d instruction items (%0d memory loads, %0d jumps taken),",
                 sent, n_loads, n_jumps_taken);
        $display("%0d result items checked, %0d mismatches", sb.checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0)
            $display("x86_real_mode_exec_subset_unit verification clean");
        else
            $display("x86_real_mode_exec_subset_unit verification failed");
        $finish;
    end
endmodule
